// ===== hdl/e2q_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// e2q_pkg
// Shared constants, arctangent table and helpers for the Euler to quaternion
// converter.
// ----------------------------------------------------------------------------
package e2q_pkg;

  localparam int CORDIC_STEPS_DEF = 16;
  localparam int OUT_WIDTH_DEF    = 16;
  localparam int TABLE_LEN        = 24;
  localparam int ANGLE_W          = 16;
  localparam int CW               = 32;  // CORDIC datapath width, Q2.29
  localparam int MW               = 22;  // sine and cosine after rounding, Q2.20
  localparam int PW               = 44;  // two-factor product, Q.40
  localparam int SW               = 68;  // triple-product sum, Q.60
  localparam int MID_FRAC         = 20;
  localparam int ANG_TO_MID       = 9;
  localparam logic signed [ANGLE_W-1:0] ANGLE_LIMIT = 16'sd25736;
  localparam logic signed [CW-1:0]      GAIN_Q29    = 32'sd326016437;

  function automatic logic signed [CW-1:0] arctan(input int i);
    logic signed [CW-1:0] r;
    case (i)
      0: r = 32'sd421657428;
      1: r = 32'sd248918915;
      2: r = 32'sd131521918;
      3: r = 32'sd66762579;
      4: r = 32'sd33510843;
      5: r = 32'sd16771758;
      6: r = 32'sd8387925;
      7: r = 32'sd4194219;
      8: r = 32'sd2097141;
      9: r = 32'sd1048575;
      default: r = CW'(32'sd1 <<< (29 - i));
    endcase
    return r;
  endfunction

endpackage

// ===== hdl/e2q_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// e2q_angle_if / e2q_quat_if
// Valid-ready channels for the angle triple and the quaternion result.
// ----------------------------------------------------------------------------
interface e2q_angle_if;
  logic valid;
  logic ready;
  logic signed [e2q_pkg::ANGLE_W-1:0] angle_x;
  logic signed [e2q_pkg::ANGLE_W-1:0] angle_y;
  logic signed [e2q_pkg::ANGLE_W-1:0] angle_z;
  modport source (output valid, angle_x, angle_y, angle_z, input ready);
  modport sink (input valid, angle_x, angle_y, angle_z, output ready);
endinterface

interface e2q_quat_if #(parameter int OUT_WIDTH = e2q_pkg::OUT_WIDTH_DEF);
  logic valid;
  logic ready;
  logic signed [OUT_WIDTH-1:0] quat_x;
  logic signed [OUT_WIDTH-1:0] quat_y;
  logic signed [OUT_WIDTH-1:0] quat_z;
  logic signed [OUT_WIDTH-1:0] quat_w;
  modport source (output valid, quat_x, quat_y, quat_z, quat_w, input ready);
  modport sink (input valid, quat_x, quat_y, quat_z, quat_w, output ready);
endinterface

// ===== hdl/e2q_cordic_lane.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// e2q_cordic_lane
// Unrolled, pipelined rotation-mode CORDIC: one register stage per step,
// then a rounding stage to Q2.20. Advances only when en is high.
// ----------------------------------------------------------------------------
module e2q_cordic_lane #(
  parameter int CORDIC_STEPS = e2q_pkg::CORDIC_STEPS_DEF
) (
  input  logic                                clk,
  input  logic                                en,
  input  logic signed [e2q_pkg::ANGLE_W-1:0]  angle,
  output logic signed [e2q_pkg::MW-1:0]       cos_h,
  output logic signed [e2q_pkg::MW-1:0]       sin_h
);
  localparam int CW = e2q_pkg::CW;

  logic signed [CW-1:0] xs [CORDIC_STEPS+1];
  logic signed [CW-1:0] ys [CORDIC_STEPS+1];
  logic signed [CW-1:0] zs [CORDIC_STEPS+1];
  logic signed [e2q_pkg::ANGLE_W-1:0] clamped;
  logic signed [CW-1:0] x_rnd;
  logic signed [CW-1:0] y_rnd;

  always_comb begin
    if (angle > e2q_pkg::ANGLE_LIMIT) begin
      clamped = e2q_pkg::ANGLE_LIMIT;
    end else if (angle < -e2q_pkg::ANGLE_LIMIT) begin
      clamped = -e2q_pkg::ANGLE_LIMIT;
    end else begin
      clamped = angle;
    end
  end

  // Stage 0 holds the clamped half-angle in Q2.29.
  always_ff @(posedge clk) begin
    if (en) begin
      xs[0] <= e2q_pkg::GAIN_Q29;
      ys[0] <= '0;
      zs[0] <= $signed({clamped, 16'd0}) >>> 1;
    end
  end

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
    always_ff @(posedge clk) begin
      if (en) begin
        if (!zs[i][CW-1]) begin
          xs[i+1] <= xs[i] - (ys[i] >>> i);
          ys[i+1] <= ys[i] + (xs[i] >>> i);
          zs[i+1] <= zs[i] - e2q_pkg::arctan(i);
        end else begin
          xs[i+1] <= xs[i] + (ys[i] >>> i);
          ys[i+1] <= ys[i] - (xs[i] >>> i);
          zs[i+1] <= zs[i] + e2q_pkg::arctan(i);
        end
      end
    end
  end

  assign x_rnd = (xs[CORDIC_STEPS] + CW'(1 << (e2q_pkg::ANG_TO_MID - 1)))
                 >>> e2q_pkg::ANG_TO_MID;
  assign y_rnd = (ys[CORDIC_STEPS] + CW'(1 << (e2q_pkg::ANG_TO_MID - 1)))
                 >>> e2q_pkg::ANG_TO_MID;

  always_ff @(posedge clk) begin
    if (en) begin
      cos_h <= x_rnd[e2q_pkg::MW-1:0];
      sin_h <= y_rnd[e2q_pkg::MW-1:0];
    end
  end
endmodule

// ===== hdl/e2q_merge.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// e2q_merge
// Combines the three lanes' sine and cosine into the quaternion: pair
// products, triple products, sums, then rounding and saturation.
// ----------------------------------------------------------------------------
module e2q_merge #(
  parameter int OUT_WIDTH = e2q_pkg::OUT_WIDTH_DEF
) (
  input  logic                            clk,
  input  logic                            en,
  input  logic signed [e2q_pkg::MW-1:0]   cx, sx, cy, sy, cz, sz,
  output logic signed [OUT_WIDTH-1:0]     qx, qy, qz, qw
);
  localparam int MW = e2q_pkg::MW;
  localparam int PW = e2q_pkg::PW;
  localparam int SW = e2q_pkg::SW;
  localparam int SH = 3 * e2q_pkg::MID_FRAC - (OUT_WIDTH - 1);

  logic signed [PW-1:0] cycx, cysx, sycx, sysx;
  logic signed [MW-1:0] cz_d, sz_d;
  logic signed [SW-1:0] t [8];
  logic signed [SW-1:0] sum [4];
  logic signed [OUT_WIDTH-1:0] res [4];

  always_ff @(posedge clk) begin
    if (en) begin
      cycx <= PW'(cy * cx);
      cysx <= PW'(cy * sx);
      sycx <= PW'(sy * cx);
      sysx <= PW'(sy * sx);
      cz_d <= cz;
      sz_d <= sz;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      t[0] <= SW'(cysx) * SW'(cz_d);
      t[1] <= SW'(sycx) * SW'(sz_d);
      t[2] <= SW'(sycx) * SW'(cz_d);
      t[3] <= SW'(cysx) * SW'(sz_d);
      t[4] <= SW'(cycx) * SW'(sz_d);
      t[5] <= SW'(sysx) * SW'(cz_d);
      t[6] <= SW'(cycx) * SW'(cz_d);
      t[7] <= SW'(sysx) * SW'(sz_d);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sum[0] <= t[0] + t[1];
      sum[1] <= t[2] - t[3];
      sum[2] <= t[4] - t[5];
      sum[3] <= t[6] + t[7];
    end
  end

  always_comb begin
    logic signed [SW-1:0] v;
    for (int k = 0; k < 4; k++) begin
      v = (sum[k] + (SW'(1) <<< (SH - 1))) >>> SH;
      if (v > SW'((64'sd1 <<< (OUT_WIDTH - 1)) - 1)) begin
        res[k] = {1'b0, {(OUT_WIDTH-1){1'b1}}};
      end else if (v < -(SW'(1) <<< (OUT_WIDTH - 1))) begin
        res[k] = {1'b1, {(OUT_WIDTH-1){1'b0}}};
      end else begin
        res[k] = v[OUT_WIDTH-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      qx <= res[0];
      qy <= res[1];
      qz <= res[2];
      qw <= res[3];
    end
  end
endmodule

// ===== hdl/euler_to_quaternion.sv =====
`timescale 1ns / 1ps
// Throughput: one item per cycle; three CORDIC lanes and the merge pipeline
// each take a new item every cycle. The whole pipeline stalls only when the
// output holds a result that is not taken. Reset clears the valid bits only.
// ----------------------------------------------------------------------------
// euler_to_quaternion
// Euler angles in Q3.13 to a saturated Q1.15 quaternion.
// ----------------------------------------------------------------------------
module euler_to_quaternion #(
  parameter int CORDIC_STEPS = e2q_pkg::CORDIC_STEPS_DEF,
  parameter int OUT_WIDTH    = e2q_pkg::OUT_WIDTH_DEF
) (
  input logic         clk,
  input logic         rst,
  e2q_angle_if.sink   in_ch,
  e2q_quat_if.source  out_ch
);
  localparam int LAT = CORDIC_STEPS + 6;

  logic [LAT-1:0] vld;
  logic en;
  logic signed [e2q_pkg::MW-1:0] c [3];
  logic signed [e2q_pkg::MW-1:0] s [3];

  // The pipeline moves when the output stage is empty or is being drained.
  assign en = !vld[LAT-1] || out_ch.ready;
  assign in_ch.ready = en;
  assign out_ch.valid = vld[LAT-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[LAT-2:0], in_ch.valid};
    end
  end

  e2q_cordic_lane #(.CORDIC_STEPS(CORDIC_STEPS)) u_lane_x (
    .clk(clk), .en(en), .angle(in_ch.angle_x), .cos_h(c[0]), .sin_h(s[0]));
  e2q_cordic_lane #(.CORDIC_STEPS(CORDIC_STEPS)) u_lane_y (
    .clk(clk), .en(en), .angle(in_ch.angle_y), .cos_h(c[1]), .sin_h(s[1]));
  e2q_cordic_lane #(.CORDIC_STEPS(CORDIC_STEPS)) u_lane_z (
    .clk(clk), .en(en), .angle(in_ch.angle_z), .cos_h(c[2]), .sin_h(s[2]));

  e2q_merge #(.OUT_WIDTH(OUT_WIDTH)) u_merge (
    .clk(clk), .en(en),
    .cx(c[0]), .sx(s[0]), .cy(c[1]), .sy(s[1]), .cz(c[2]), .sz(s[2]),
    .qx(out_ch.quat_x), .qy(out_ch.quat_y), .qz(out_ch.quat_z),
    .qw(out_ch.quat_w));
endmodule

// ===== hdl/e2q_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// e2q_checker
// Port-level checks for the converter, bound to the top level.
// ----------------------------------------------------------------------------
module e2q_checker (
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic [15:0] quat_w
);
  a_stall: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(quat_w))
    else $error("stalled result changed");
  a_ready: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input blocked while output empty");
  a_back: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |-> !in_ready)
    else $error("input taken while output stalled");
  a_reset: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result after reset");
endmodule

bind euler_to_quaternion e2q_checker u_chk (
  .clk(clk), .rst(rst), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready),
  .quat_w(out_ch.quat_w[15:0]));
